// File: sv/lbf_pkg.sv
package lbf_pkg;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_ZERO    = 2'd1;
  localparam status_t STATUS_INVALID = 2'd2;
  localparam status_t STATUS_SAT     = 2'd3;

  // stage counts of the iterative sections
  localparam int NSQRT = 32;
  localparam int ND1   = 62;
  localparam int ND2   = 30;

  // fraction bits of beta and gamma
  localparam int BETA_FRAC = 30;

  // per-word data that rides along the pipe
  typedef struct packed {
    logic               zero;
    logic               inv;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [37:0] bdp;
    logic signed [31:0] e;
    logic               esat;
  } side_t;

  // saturated value with overflow flag
  typedef struct packed {
    logic               ov;
    logic signed [31:0] v;
  } sat_t;

  function automatic sat_t sat32(input logic signed [69:0] x);
    sat_t r;
    r.ov = 1'b0;
    r.v  = x[31:0];
    if (x > 70'sh7FFF_FFFF) begin
      r.ov = 1'b1;
      r.v  = 32'sh7FFF_FFFF;
    end else if (x < -70'sh8000_0000) begin
      r.ov = 1'b1;
      r.v  = -32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

// File: sv/lorentz_boost_four_vector_unit.sv
// Lorentz boost of one four-momentum into the frame moving with velocity beta.
// Input channel: in_valid/in_ready with beta_x/y/z (signed Q2.30, units of c) and
// energy_in, mom_x_in, mom_y_in, mom_z_in (signed Q16.16 GeV).
// Output channel: out_valid/out_ready with energy_out, mom_x/y/z_out (signed Q16.16,
// saturated) and status: 0 ok, 1 zero beta passthrough, 2 beta not below one
// (outputs zero), 3 a component saturated.
// The datapath is one pipeline: products and sums, a 32-stage square root (one
// result bit per stage), a 62-stage divider for gamma and a 30-stage divider for
// the (gamma-1)/beta^2 term (one quotient bit per stage), then split multiplies
// with rounding and saturation.
// Throughput is one word per cycle while the output is not stalled.
// Reset clears all valid bits; the pipe holds no other state.
// When the receiver stalls with a word waiting at the output, the whole pipe holds
// and in_ready drops; a word waiting in any earlier stage does not block input.
module lorentz_boost_four_vector_unit import lbf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] beta_x,
  input  logic signed [31:0] beta_y,
  input  logic signed [31:0] beta_z,
  input  logic signed [31:0] energy_in,
  input  logic signed [31:0] mom_x_in,
  input  logic signed [31:0] mom_y_in,
  input  logic signed [31:0] mom_z_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] energy_out,
  output logic signed [31:0] mom_x_out,
  output logic signed [31:0] mom_y_out,
  output logic signed [31:0] mom_z_out,
  output status_t            status
);

  localparam int S_SUM = 1;
  localparam int S_SQ  = 2;
  localparam int S_D1  = S_SQ + NSQRT;
  localparam int S_D2  = S_D1 + ND1;
  localparam int S_M0  = S_D2 + ND2;
  localparam int S_M1  = S_M0 + 1;
  localparam int S_M2  = S_M1 + 1;
  localparam int S_M3  = S_M2 + 1;
  localparam int S_M4  = S_M3 + 1;
  localparam int S_M5  = S_M4 + 1;
  localparam int S_OUT = S_M5 + 1;
  localparam int NST   = S_OUT + 1;

  localparam logic [63:0]         ONE_B2 = 64'd1 << (2 * BETA_FRAC);
  localparam logic signed [65:0]  RND66  = 66'sd1 <<< (BETA_FRAC - 1);
  localparam logic signed [99:0]  RND100 = 100'sd1 <<< (BETA_FRAC - 1);
  localparam logic signed [95:0]  RND96  = 96'sd1 <<< (BETA_FRAC - 1);
  localparam logic [60:0]         ONE_G  = 61'd1 << BETA_FRAC;
  localparam logic signed [69:0]  W_MAX  = 70'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [69:0]  W_MIN  = -W_MAX - 70'sd1;

  logic            adv;
  logic [NST-1:0]  vld;
  side_t           side [NST];
  side_t           side_in;
  side_t           side_sum;
  side_t           side_m3;

  // pipe advances unless the output word is stalled
  assign adv       = !vld[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // input capture into the side data
  always_comb begin
    side_in      = '0;
    side_in.bx   = beta_x;
    side_in.by   = beta_y;
    side_in.bz   = beta_z;
    side_in.t    = energy_in;
    side_in.px   = mom_x_in;
    side_in.py   = mom_y_in;
    side_in.pz   = mom_z_in;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
    end
  end

  // side data shift, with updates at the sum and rounding stages
  for (genvar g = 1; g < NST; g++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        if (g == S_SUM) begin
          side[g] <= side_sum;
        end else if (g == S_M3) begin
          side[g] <= side_m3;
        end else begin
          side[g] <= side[g-1];
        end
      end
    end
  end

  // stage 0: squares of |beta_i| and beta_i * p_i
  logic [31:0]        mx, my, mz;
  logic [63:0]        sq0, sq1, sq2;
  logic signed [63:0] bp0, bp1, bp2;

  assign mx = beta_x[31] ? 32'(-beta_x) : beta_x;
  assign my = beta_y[31] ? 32'(-beta_y) : beta_y;
  assign mz = beta_z[31] ? 32'(-beta_z) : beta_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq0 <= mx * mx;
      sq1 <= my * my;
      sq2 <= mz * mz;
      bp0 <= 64'(beta_x) * 64'(mom_x_in);
      bp1 <= 64'(beta_y) * 64'(mom_y_in);
      bp2 <= 64'(beta_z) * 64'(mom_z_in);
    end
  end

  // stage 1: beta^2, dot product, special-case flags, sqrt radicand
  logic [63:0]        b2;
  logic signed [65:0] dacc;
  logic [63:0]        dfree;
  logic [63:0]        rad;

  always_comb begin
    b2                = sq0 + sq1 + sq2;
    dacc              = 66'(bp0) + 66'(bp1) + 66'(bp2) + RND66;
    side_sum          = side[0];
    side_sum.bdp      = 38'(dacc >>> BETA_FRAC);
    side_sum.zero     = (b2 == 64'd0);
    side_sum.inv      = (b2 >= ONE_B2);
    dfree             = ONE_B2 - b2;
    side_sum.esat     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad <= side_sum.inv ? 64'd0 : (dfree << 2);
    end
  end

  // square root, one result bit per stage
  logic [63:0] sqv [NSQRT];
  logic [63:0] sqr [NSQRT];

  for (genvar k = 0; k < NSQRT; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] v_in, r_in, sum;
    logic        ge;
    if (k == 0) begin : g_first
      assign v_in = rad;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = sqv[k-1];
      assign r_in = sqr[k-1];
    end
    assign sum = r_in + BITV;
    assign ge  = (v_in >= sum);
    always_ff @(posedge clk) begin
      if (adv) begin
        sqv[k] <= ge ? v_in - sum : v_in;
        sqr[k] <= ge ? (r_in >> 1) + BITV : (r_in >> 1);
      end
    end
  end

  // gamma = 2^61 / s, one quotient bit per stage
  logic [32:0] d1r [ND1];
  logic [61:0] d1q [ND1];
  logic [31:0] d1s [ND1];

  for (genvar j = 0; j < ND1; j++) begin : g_div1
    logic [31:0] s_in;
    logic [32:0] r_in, rsh;
    logic [61:0] q_in;
    logic        ge;
    if (j == 0) begin : g_first
      assign s_in = sqr[NSQRT-1][31:0];
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign s_in = d1s[j-1];
      assign r_in = d1r[j-1];
      assign q_in = d1q[j-1];
    end
    assign rsh = {r_in[31:0], (j == 0) ? 1'b1 : 1'b0};
    assign ge  = (rsh >= {1'b0, s_in});
    always_ff @(posedge clk) begin
      if (adv) begin
        d1s[j] <= s_in;
        d1r[j] <= ge ? rsh - {1'b0, s_in} : rsh;
        d1q[j] <= {q_in[60:0], ge};
      end
    end
  end

  // 2^60 / (gamma + 1), one quotient bit per stage
  logic [60:0] d2g [ND2];
  logic [60:0] d2d [ND2];
  logic [60:0] d2r [ND2];
  logic [29:0] d2q [ND2];

  for (genvar j = 0; j < ND2; j++) begin : g_div2
    logic [60:0] g_in, dv_in, r_in;
    logic [29:0] q_in;
    logic [61:0] rsh;
    logic        ge;
    if (j == 0) begin : g_first
      assign g_in  = d1q[ND1-1][60:0];
      assign dv_in = d1q[ND1-1][60:0] + ONE_G;
      assign r_in  = ONE_G;
      assign q_in  = '0;
    end else begin : g_next
      assign g_in  = d2g[j-1];
      assign dv_in = d2d[j-1];
      assign r_in  = d2r[j-1];
      assign q_in  = d2q[j-1];
    end
    assign rsh = {r_in, 1'b0};
    assign ge  = (rsh >= {1'b0, dv_in});
    always_ff @(posedge clk) begin
      if (adv) begin
        d2g[j] <= g_in;
        d2d[j] <= dv_in;
        d2r[j] <= ge ? 61'(rsh - {1'b0, dv_in}) : 61'(rsh);
        d2q[j] <= {q_in[28:0], ge};
      end
    end
  end

  // m0: factor and t - b.p
  logic [60:0]        gam0, fac0;
  logic signed [37:0] xd0;

  always_ff @(posedge clk) begin
    if (adv) begin
      gam0 <= d2g[ND2-1];
      fac0 <= d2g[ND2-1] - ONE_G + 61'(d2q[ND2-1]);
      xd0  <= 38'(side[S_M0-1].t) - side[S_M0-1].bdp;
    end
  end

  // m1: partial products with gamma and factor split in halves
  logic signed [31:0] gl, fl;
  logic signed [30:0] gh, fh;
  logic signed [69:0] pel, peh, pfl, pfh, pgl, pgh;

  assign gl = $signed({1'b0, gam0[30:0]});
  assign gh = $signed({1'b0, gam0[60:31]});
  assign fl = $signed({1'b0, fac0[30:0]});
  assign fh = $signed({1'b0, fac0[60:31]});

  always_ff @(posedge clk) begin
    if (adv) begin
      pel <= 70'(gl) * 70'(xd0);
      peh <= 70'(gh) * 70'(xd0);
      pfl <= 70'(fl) * 70'(side[S_M0].bdp);
      pfh <= 70'(fh) * 70'(side[S_M0].bdp);
      pgl <= 70'(gl) * 70'(side[S_M0].t);
      pgh <= 70'(gh) * 70'(side[S_M0].t);
    end
  end

  // m2: recombine partial products, add rounding half
  logic signed [99:0] eacc, wacc;

  always_ff @(posedge clk) begin
    if (adv) begin
      eacc <= (100'(peh) <<< 31) + 100'(pel) + RND100;
      wacc <= (100'(pfh) <<< 31) + 100'(pfl) - (100'(pgh) <<< 31) - 100'(pgl) + RND100;
    end
  end

  // m3: energy result and clamped w
  logic signed [69:0] esh, wsh;
  logic signed [63:0] ws;
  sat_t               esr;

  always_comb begin
    esh          = 70'(eacc >>> BETA_FRAC);
    wsh          = 70'(wacc >>> BETA_FRAC);
    esr          = sat32(esh);
    side_m3      = side[S_M2];
    side_m3.e    = esr.v;
    side_m3.esat = esr.ov;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (wsh > W_MAX) begin
        ws <= W_MAX[63:0];
      end else if (wsh < W_MIN) begin
        ws <= W_MIN[63:0];
      end else begin
        ws <= wsh[63:0];
      end
    end
  end

  // m4: w * beta_i with w split in halves
  logic signed [32:0] wl;
  logic signed [31:0] wh;
  logic signed [31:0] bsel [3];
  logic signed [64:0] ql [3];
  logic signed [63:0] qh [3];
  logic signed [95:0] qacc [3];
  logic signed [31:0] psel [3];
  sat_t               qs [3];

  assign wl      = $signed({1'b0, ws[31:0]});
  assign wh      = ws[63:32];
  assign bsel[0] = side[S_M3].bx;
  assign bsel[1] = side[S_M3].by;
  assign bsel[2] = side[S_M3].bz;
  assign psel[0] = side[S_M5].px;
  assign psel[1] = side[S_M5].py;
  assign psel[2] = side[S_M5].pz;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        ql[i]   <= 65'(wl) * 65'(bsel[i]);
        qh[i]   <= 64'(wh) * 64'(bsel[i]);
        // m5: recombine and add rounding half
        qacc[i] <= (96'(qh[i]) <<< 32) + 96'(ql[i]) + RND96;
      end
    end
    // m6: round, add momentum, saturate
    assign qs[i] = sat32(70'(67'(66'(qacc[i] >>> BETA_FRAC)) + 67'(psel[i])));
  end

  // output word register
  always_ff @(posedge clk) begin
    if (adv) begin
      if (side[S_M5].zero) begin
        energy_out <= side[S_M5].t;
        mom_x_out  <= side[S_M5].px;
        mom_y_out  <= side[S_M5].py;
        mom_z_out  <= side[S_M5].pz;
        status     <= STATUS_ZERO;
      end else if (side[S_M5].inv) begin
        energy_out <= '0;
        mom_x_out  <= '0;
        mom_y_out  <= '0;
        mom_z_out  <= '0;
        status     <= STATUS_INVALID;
      end else begin
        energy_out <= side[S_M5].e;
        mom_x_out  <= qs[0].v;
        mom_y_out  <= qs[1].v;
        mom_z_out  <= qs[2].v;
        status     <= (side[S_M5].esat || qs[0].ov || qs[1].ov || qs[2].ov) ?
                      STATUS_SAT : STATUS_OK;
      end
    end
  end

endmodule

// File: tb/lorentz_boost_four_vector_unit_tb.sv
module lorentz_boost_four_vector_unit_tb import lbf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] bx, by, bz, t, px, py, pz;
  } boost_word_t;

  typedef struct {
    logic signed [31:0] e, qx, qy, qz;
    status_t            st;
  } boosted_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] beta_x = '0, beta_y = '0, beta_z = '0;
  logic signed [31:0] energy_in = '0, mom_x_in = '0, mom_y_in = '0, mom_z_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] energy_out, mom_x_out, mom_y_out, mom_z_out;
  status_t            status;

  boost_word_t   pending_words[$];
  boosted_word_t expected_boosts[$];
  int            mismatches = 0;
  bit            sent_word = 1'b0;
  int            send_gap = 0;
  int            recv_gap = 0;
  bit            calm = 1'b0;

  lorentz_boost_four_vector_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .beta_x(beta_x), .beta_y(beta_y), .beta_z(beta_z), .energy_in(energy_in),
    .mom_x_in(mom_x_in), .mom_y_in(mom_y_in), .mom_z_in(mom_z_in),
    .out_valid(out_valid), .out_ready(out_ready), .energy_out(energy_out),
    .mom_x_out(mom_x_out), .mom_y_out(mom_y_out), .mom_z_out(mom_z_out),
    .status(status)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'h1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // round half up then arithmetic shift
  function automatic wide_t round_shift(wide_t x, int k);
    wide_t half;
    half = wide_t'(1) <<< (k - 1);
    return (x + half) >>> k;
  endfunction

  function automatic wide_t clamp64(wide_t x);
    wide_t hi, lo;
    hi = 128'sh7FFF_FFFF_FFFF_FFFF;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t x, inout bit ov);
    wide_t hi, lo;
    hi = 128'sh7FFF_FFFF;
    lo = -hi - 1;
    if (x > hi) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (x < lo) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // boosted four-vector of one input word
  function automatic boosted_word_t boost(boost_word_t w);
    boosted_word_t r;
    longint signed   bx, by, bz, gamma, factor;
    longint unsigned b2, d, s;
    wide_t           bdp, ws, acc, g, f;
    bit              ov;
    bx = w.bx;
    by = w.by;
    bz = w.bz;
    ov = 1'b0;
    b2 = longint'(bx * bx);
    b2 = b2 + longint'(by * by) + longint'(bz * bz);
    if (b2 == 0) begin
      r.e = w.t; r.qx = w.px; r.qy = w.py; r.qz = w.pz; r.st = STATUS_ZERO;
      return r;
    end
    if (b2 >= (64'h1 << 60)) begin
      r.e = '0; r.qx = '0; r.qy = '0; r.qz = '0; r.st = STATUS_INVALID;
      return r;
    end
    d = (64'h1 << 60) - b2;
    s = floor_sqrt(d << 2);
    gamma = (64'h1 << 61) / s;
    factor = gamma - (64'sh1 << 30) + longint'((64'h1 << 60) / (gamma + (64'h1 << 30)));
    g = gamma;
    f = factor;
    acc = wide_t'(w.bx) * wide_t'(w.px) + wide_t'(w.by) * wide_t'(w.py)
        + wide_t'(w.bz) * wide_t'(w.pz);
    bdp = clamp64(round_shift(acc, 30));
    r.e = clamp32(round_shift(g * (wide_t'(w.t) - bdp), 30), ov);
    ws = clamp64(round_shift(f * bdp - g * wide_t'(w.t), 30));
    r.qx = clamp32(round_shift(ws * wide_t'(w.bx), 30) + wide_t'(w.px), ov);
    r.qy = clamp32(round_shift(ws * wide_t'(w.by), 30) + wide_t'(w.py), ov);
    r.qz = clamp32(round_shift(ws * wide_t'(w.bz), 30) + wide_t'(w.pz), ov);
    r.st = ov ? STATUS_SAT : STATUS_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || sent_word) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          boost_word_t w;
          w = pending_words.pop_front();
          // switch between calm and gappy stretches now and then
          if (pending_words.size() % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
          beta_x <= w.bx; beta_y <= w.by; beta_z <= w.bz;
          energy_in <= w.t; mom_x_in <= w.px; mom_y_in <= w.py; mom_z_in <= w.pz;
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // monitor: predict on input words, check output words
  always @(posedge clk) begin
    sent_word <= (!rst && in_valid && in_ready);
    if (!rst && in_valid && in_ready) begin
      boost_word_t w;
      w.bx = beta_x; w.by = beta_y; w.bz = beta_z;
      w.t = energy_in; w.px = mom_x_in; w.py = mom_y_in; w.pz = mom_z_in;
      expected_boosts.push_back(boost(w));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_boosts.size() == 0) begin
        report_mismatch("unexpected word, energy", energy_out, 0);
      end else begin
        boosted_word_t x;
        x = expected_boosts.pop_front();
        if (energy_out !== x.e) report_mismatch("energy_out", energy_out, x.e);
        if (mom_x_out !== x.qx) report_mismatch("mom_x_out", mom_x_out, x.qx);
        if (mom_y_out !== x.qy) report_mismatch("mom_y_out", mom_y_out, x.qy);
        if (mom_z_out !== x.qz) report_mismatch("mom_z_out", mom_z_out, x.qz);
        if (status !== x.st) report_mismatch("status", status, x.st);
      end
    end
  end

  function automatic boost_word_t make_word(int bx, int by, int bz, int t, int px, int py,
                                            int pz);
    boost_word_t w;
    w.bx = bx; w.by = by; w.bz = bz; w.t = t; w.px = px; w.py = py; w.pz = pz;
    return w;
  endfunction

  function automatic int rand_beta(int kind);
    case (kind)
      0: return 0;
      1: return $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
      2: return $signed($urandom_range(0, 32'h1FFF)) - 32'sh1000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic int rand_mom();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    return $signed($urandom());
  endfunction

  // stimulus and end of run
  initial begin
    int mode;
    boost_word_t w;
    // directed words
    pending_words.push_back(make_word(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, -1));
    pending_words.push_back(make_word(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, -1));
    pending_words.push_back(make_word(32'h4000_0000, 0, 0, 65536, 0, 0, 0));
    pending_words.push_back(make_word(0, 0, 32'h8000_0000, 65536, 1, 2, 3));
    pending_words.push_back(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1, 1));
    pending_words.push_back(make_word(32'h3FFF_FFFF, 0, 0, 65536, 0, 0, 0));
    pending_words.push_back(make_word(0, -32'sh3FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 5, 0));
    pending_words.push_back(make_word(1, 0, 0, 65536, 65536, 0, 0));
    pending_words.push_back(make_word(-1, -1, -1, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000));
    pending_words.push_back(make_word(32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
                                      32'h0010_0000, 32'h7FFF_FFFF, -5, 32'h8000_0000));
    pending_words.push_back(make_word(32'h3000_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      0, 0));
    pending_words.push_back(make_word(-32'sh3000_0000, 0, 0, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 0, 0));
    pending_words.push_back(make_word(32'h2000_0000, -32'sh1000_0000, 32'h0800_0000,
                                      32'h0003_0000, 32'h0001_0000, -32'sh0002_0000, 7));
    pending_words.push_back(make_word(32'h3FFF_0000, 0, 0, 32'h0100_0000, -32'sh0100_0000,
                                      0, 0));
    // random words
    for (int i = 0; i < 1900; i++) begin
      mode = $urandom_range(0, 19);
      if (mode < 1) w = make_word(0, 0, 0, 0, 0, 0, 0);
      else if (mode < 13)
        w = make_word(rand_beta(1), rand_beta(1), rand_beta(1), 0, 0, 0, 0);
      else if (mode < 15)
        w = make_word(rand_beta(2), rand_beta(2), rand_beta(2), 0, 0, 0, 0);
      else
        w = make_word(rand_beta(3), rand_beta($urandom_range(0, 3)),
                      rand_beta($urandom_range(0, 3)), 0, 0, 0, 0);
      w.t = rand_mom(); w.px = rand_mom(); w.py = rand_mom(); w.pz = rand_mom();
      pending_words.push_back(w);
    end
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_boosts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_boosts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
sv/lbf_pkg.sv
sv/lorentz_boost_four_vector_unit.sv
tb/lorentz_boost_four_vector_unit_tb.sv
